>>> hdl/frame_bitmap_allocator_top_assert.svh
// assertion macros for the frame bitmap allocator
`ifndef FRAME_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// condition holds at every edge outside reset
`define FBA_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequence in the same cycle
`define FBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the next cycle
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fba_pkg.sv
// shared types and constants of the frame bitmap allocator
`default_nettype none

package fba_pkg;

    localparam int FRAME_W     = 12;
    localparam int CFG_W       = 13;
    localparam int REM_W       = 14;
    localparam int FIELD_LIMIT = 4096;
    localparam int COUNT_RESET = 4096;

    typedef enum logic [2:0] {
        ST_ALLOCATED = 3'd0,
        ST_MAPPED    = 3'd1,
        ST_NO_FREE   = 3'd2,
        ST_FREED     = 3'd3,
        ST_NOTHING   = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_SCAN  = 2'd2,
        S_DONE  = 2'd3
    } state_t;

    typedef struct packed {
        action_t              action;
        logic [FRAME_W-1:0]   page_frame;
        logic                 kernel_page;
        logic                 writable_page;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [FRAME_W-1:0]   frame_out;
        logic                 present_bit;
        logic                 rw_bit;
        logic                 user_bit;
    } out_item_t;

    // verdict of the word unit on one bitmap word
    typedef struct packed {
        logic hit;
        logic miss;
    } word_scan_t;

endpackage

`default_nettype wire

>>> hdl/fba_word_unit.sv
// word unit: first free bit search, bit set and bit clear on one bitmap word
`default_nettype none

module fba_word_unit #(
    parameter int WORD_BITS = 32
) (
    input  wire logic [WORD_BITS-1:0]                       word_in,
    input  wire fba_pkg::action_t                           mode,
    input  wire logic signed [fba_pkg::REM_W-1:0]           rem,
    output fba_pkg::word_scan_t                             scan,
    output logic [((WORD_BITS > 1) ? $clog2(WORD_BITS) : 1)-1:0] lane,
    output logic [WORD_BITS-1:0]                            word_out,
    output logic signed [fba_pkg::REM_W-1:0]                rem_next
);

    localparam int LANE_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic signed [fba_pkg::REM_W-1:0] WB_S = fba_pkg::REM_W'(WORD_BITS);

    logic              alloc_hit;
    logic [LANE_W-1:0] alloc_lane;
    logic [WORD_BITS-1:0] lane_mask;

    // lowest free bit that still lies below the bound
    always_comb begin
        alloc_hit  = 1'b0;
        alloc_lane = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word_in[i] && (signed'(fba_pkg::REM_W'(i)) < rem)) begin
                alloc_hit  = 1'b1;
                alloc_lane = LANE_W'(i);
            end
        end
    end

    assign rem_next = rem - WB_S;

    always_comb begin
        scan = '0;
        lane = alloc_lane;
        if (mode == fba_pkg::ACT_FREE) begin
            // remaining offset below one word means the frame sits here
            scan.hit = (rem < WB_S);
            lane     = rem[LANE_W-1:0];
        end else begin
            scan.hit  = alloc_hit;
            scan.miss = !alloc_hit && (rem_next <= 0);
        end
    end

    assign lane_mask = WORD_BITS'(1) << lane;
    assign word_out  = (mode == fba_pkg::ACT_FREE) ? (word_in & ~lane_mask)
                                                   : (word_in | lane_mask);

endmodule

`default_nettype wire

>>> hdl/frame_bitmap_allocator_top.sv
// frame bitmap allocator top level: bitmap memory, scan sequencer, result register
//
//  channel | dir | handshake             | word
//  s_      | in  | s_valid / s_ready     | fba_pkg::in_item_t
//  m_      | out | m_valid / m_ready     | fba_pkg::out_item_t
//  cfg_    | in  | cfg_valid / cfg_ready | frame_count, 13 bits
//
// the bitmap memory is read one word per cycle by a single word unit
// allocate: scans n words from word zero, n up to bound / WORD_BITS rounded up (128 at default)
// free: scans words up to the frame's word; mapped, nothing to free, zero bound, free past the bitmap: straight to done
// after reset a clearing pass writes zeros to all WORD_COUNT words (128 at default), s_ready low
// one item at a time; the output register holds a result while the next word is accepted
// a full output register with m_ready low holds the sequencer in done and s_ready low
`default_nettype none

`include "frame_bitmap_allocator_top_assert.svh"

module frame_bitmap_allocator_top #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire fba_pkg::in_item_t             s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output fba_pkg::out_item_t                 m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fba_pkg::CFG_W-1:0]     cfg_data
);

    localparam int WORD_COUNT   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int LANE_W       = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int SEARCH_LIMIT = (MAX_FRAMES < fba_pkg::FIELD_LIMIT) ? MAX_FRAMES
                                                                      : fba_pkg::FIELD_LIMIT;
    localparam logic [31:0] MAX_FRAMES_L = 32'(MAX_FRAMES);
    localparam logic [fba_pkg::CFG_W-1:0] LIMIT_L = fba_pkg::CFG_W'(SEARCH_LIMIT);

    // bitmap memory
    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    fba_pkg::state_t  state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [fba_pkg::CFG_W-1:0] frame_count_reg;
    fba_pkg::action_t mode_reg, mode_next;
    logic             kernel_reg, kernel_next;
    logic             writable_reg, writable_next;
    logic [ADDR_W-1:0] scan_idx_reg, scan_idx_next;
    logic [fba_pkg::CFG_W-1:0] base_reg, base_next;
    logic signed [fba_pkg::REM_W-1:0] rem_reg, rem_next;
    fba_pkg::out_item_t res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    fba_pkg::out_item_t m_data_reg, m_data_next;

    logic                      s_accept;
    logic                      out_load;
    logic [fba_pkg::CFG_W-1:0] bound;
    logic                      in_bitmap;
    fba_pkg::word_scan_t       scan_res;
    logic [LANE_W-1:0]         scan_lane;
    logic [WORD_BITS-1:0]      scan_word;
    logic signed [fba_pkg::REM_W-1:0] scan_rem_next;
    logic [fba_pkg::CFG_W-1:0] found_frame;

    fba_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word (
        .word_in  (rdata_reg),
        .mode     (mode_reg),
        .rem      (rem_reg),
        .scan     (scan_res),
        .lane     (scan_lane),
        .word_out (scan_word),
        .rem_next (scan_rem_next)
    );

    assign s_ready   = (state_reg == fba_pkg::S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == fba_pkg::S_DONE) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign bound       = (frame_count_reg > LIMIT_L) ? LIMIT_L : frame_count_reg;
    assign in_bitmap   = (32'(s_data.page_frame) < MAX_FRAMES_L);
    assign found_frame = base_reg + fba_pkg::CFG_W'(scan_lane);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fba_pkg::S_CLEAR: begin
                if (clr_cnt_reg == ADDR_W'(WORD_COUNT - 1)) begin
                    state_next = fba_pkg::S_IDLE;
                end
            end
            fba_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (s_data.page_frame == '0) begin
                        state_next = (s_data.action == fba_pkg::ACT_ALLOC && bound != '0)
                                     ? fba_pkg::S_SCAN : fba_pkg::S_DONE;
                    end else begin
                        state_next = (s_data.action == fba_pkg::ACT_FREE && in_bitmap)
                                     ? fba_pkg::S_SCAN : fba_pkg::S_DONE;
                    end
                end
            end
            fba_pkg::S_SCAN: begin
                if (scan_res.hit || scan_res.miss) begin
                    state_next = fba_pkg::S_DONE;
                end
            end
            fba_pkg::S_DONE: begin
                if (out_load) begin
                    state_next = fba_pkg::S_IDLE;
                end
            end
            default: state_next = fba_pkg::S_CLEAR;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        mode_next     = mode_reg;
        kernel_next   = kernel_reg;
        writable_next = writable_reg;
        scan_idx_next = scan_idx_reg;
        base_next     = base_reg;
        rem_next      = rem_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = scan_idx_reg;
        mem_wdata     = scan_word;
        mem_raddr     = scan_idx_reg + ADDR_W'(1);
        unique case (state_reg)
            fba_pkg::S_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            fba_pkg::S_IDLE: begin
                // every scan starts at word zero
                mem_raddr     = '0;
                mode_next     = s_data.action;
                kernel_next   = s_data.kernel_page;
                writable_next = s_data.writable_page;
                scan_idx_next = '0;
                base_next     = '0;
                res_next      = '0;
                if (s_data.action == fba_pkg::ACT_ALLOC) begin
                    rem_next = signed'(fba_pkg::REM_W'(bound));
                    if (s_data.page_frame != '0) begin
                        res_next.status    = fba_pkg::ST_MAPPED;
                        res_next.frame_out = s_data.page_frame;
                    end else begin
                        res_next.status = fba_pkg::ST_NO_FREE;
                    end
                end else begin
                    rem_next = signed'(fba_pkg::REM_W'(s_data.page_frame));
                    res_next.status = (s_data.page_frame == '0) ? fba_pkg::ST_NOTHING
                                                                 : fba_pkg::ST_FREED;
                end
            end
            fba_pkg::S_SCAN: begin
                res_next = '0;
                if (scan_res.hit) begin
                    mem_we = 1'b1;
                    if (mode_reg == fba_pkg::ACT_ALLOC) begin
                        res_next.status      = fba_pkg::ST_ALLOCATED;
                        res_next.frame_out   = found_frame[fba_pkg::FRAME_W-1:0];
                        res_next.present_bit = 1'b1;
                        res_next.rw_bit      = writable_reg;
                        res_next.user_bit    = !kernel_reg;
                    end else begin
                        res_next.status = fba_pkg::ST_FREED;
                    end
                end else if (scan_res.miss) begin
                    res_next.status = fba_pkg::ST_NO_FREE;
                end else begin
                    scan_idx_next = scan_idx_reg + ADDR_W'(1);
                    base_next     = base_reg + fba_pkg::CFG_W'(WORD_BITS);
                    rem_next      = scan_rem_next;
                end
            end
            fba_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = res_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fba_pkg::S_CLEAR;
            clr_cnt_reg     <= '0;
            frame_count_reg <= fba_pkg::CFG_W'(fba_pkg::COUNT_RESET);
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                frame_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        kernel_reg   <= kernel_next;
        writable_reg <= writable_next;
        scan_idx_reg <= scan_idx_next;
        base_reg     <= base_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    `FBA_ASSERT_IMP(a_no_overwrite, out_load && m_valid_reg, m_ready, "result word overwritten before taken")
    `FBA_ASSERT_NEXT(a_accept_moves, s_accept, state_reg == fba_pkg::S_SCAN || state_reg == fba_pkg::S_DONE, "accepted word did not start work")
    `FBA_ASSERT_IMP(a_rem_live, state_reg == fba_pkg::S_SCAN && mode_reg == fba_pkg::ACT_ALLOC, rem_reg > 0, "allocation scan past the bound")
    `FBA_ASSERT_IMP(a_hit_in_bound, state_reg == fba_pkg::S_SCAN && mode_reg == fba_pkg::ACT_ALLOC && scan_res.hit, found_frame < frame_count_reg, "allocated frame beyond frame count")
    `FBA_ASSERT_IMP(a_write_states, mem_we, state_reg == fba_pkg::S_CLEAR || state_reg == fba_pkg::S_SCAN, "bitmap written outside clear or scan")

endmodule

`default_nettype wire

>>> dv/frame_bitmap_allocator_top_tb.sv
// self-checking testbench for the frame bitmap allocator top level
`timescale 1ns / 1ps

module frame_bitmap_allocator_top_tb;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 90;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    fba_pkg::in_item_t          s_data;
    logic                       m_valid;
    logic                       m_ready;
    fba_pkg::out_item_t         m_data;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [fba_pkg::CFG_W-1:0]  cfg_data;

    // shadow of the usage bitmap and the frame count register
    bit [fba_pkg::FIELD_LIMIT-1:0] frame_used;
    logic [fba_pkg::CFG_W-1:0]     frame_limit;

    fba_pkg::out_item_t awaited_entries[$];
    fba_pkg::out_item_t last_entry;
    int unsigned held_frames[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int quiet_cycles;
    int error_count;
    int n_requests, n_settings;
    int n_alloc, n_mapped, n_no_free, n_freed, n_nothing;

    frame_bitmap_allocator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic fba_pkg::out_item_t page_entry_after(input fba_pkg::in_item_t w);
        fba_pkg::out_item_t r;
        int unsigned bound;
        int unsigned f;
        bit          found;
        r     = '0;
        found = 1'b0;
        if (w.action == fba_pkg::ACT_ALLOC) begin
            if (w.page_frame != 0) begin
                r.status    = fba_pkg::ST_MAPPED;
                r.frame_out = w.page_frame;
                n_mapped++;
            end else begin
                bound = (frame_limit > fba_pkg::FIELD_LIMIT) ? fba_pkg::FIELD_LIMIT
                                                             : frame_limit;
                // first fit: lowest clear bit below the bound
                for (f = 0; f < bound && !found; f++) begin
                    if (!frame_used[f]) begin
                        found         = 1'b1;
                        frame_used[f] = 1'b1;
                        r.frame_out   = fba_pkg::FRAME_W'(f);
                    end
                end
                if (found) begin
                    r.status      = fba_pkg::ST_ALLOCATED;
                    r.present_bit = 1'b1;
                    r.rw_bit      = w.writable_page;
                    r.user_bit    = !w.kernel_page;
                    n_alloc++;
                end else begin
                    r.status = fba_pkg::ST_NO_FREE;
                    n_no_free++;
                end
            end
        end else if (w.page_frame == 0) begin
            r.status = fba_pkg::ST_NOTHING;
            n_nothing++;
        end else begin
            frame_used[w.page_frame] = 1'b0;
            r.status = fba_pkg::ST_FREED;
            n_freed++;
        end
        return r;
    endfunction

    function automatic fba_pkg::in_item_t make_request(input fba_pkg::action_t act,
                                                       input int unsigned frame,
                                                       input bit kernel, input bit writable);
        fba_pkg::in_item_t w;
        w.action        = act;
        w.page_frame    = fba_pkg::FRAME_W'(frame);
        w.kernel_page   = kernel;
        w.writable_page = writable;
        return w;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic send_request(input fba_pkg::in_item_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_entry = page_entry_after(w);
        awaited_entries.push_back(last_entry);
        n_requests++;
        @(negedge aclk);
    endtask

    task automatic wait_for_results;
        s_valid <= 1'b0;
        do @(negedge aclk); while (awaited_entries.size() != 0);
    endtask

    task automatic write_frame_count(input logic [fba_pkg::CFG_W-1:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        frame_limit = value;
        n_settings++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_requests;
        // frame zero is allocatable
        send_request(make_request(fba_pkg::ACT_ALLOC, 0, 1'b0, 1'b1));
        send_request(make_request(fba_pkg::ACT_ALLOC, 0, 1'b1, 1'b0));
        send_request(make_request(fba_pkg::ACT_ALLOC, 0, 1'b1, 1'b1));
        send_request(make_request(fba_pkg::ACT_ALLOC, 0, 1'b0, 1'b0));
        send_request(make_request(fba_pkg::ACT_ALLOC, 4095, 1'b1, 1'b1));
        send_request(make_request(fba_pkg::ACT_ALLOC, 1, 1'b0, 1'b0));
        send_request(make_request(fba_pkg::ACT_ALLOC, 12'haaa, 1'b1, 1'b0));
        send_request(make_request(fba_pkg::ACT_ALLOC, 12'h555, 1'b0, 1'b1));
        send_request(make_request(fba_pkg::ACT_FREE, 2, 1'b0, 1'b0));
        // frame zero: nothing to free
        send_request(make_request(fba_pkg::ACT_FREE, 0, 1'b0, 1'b0));
        // never used
        send_request(make_request(fba_pkg::ACT_FREE, 4095, 1'b1, 1'b1));
        // second free of same frame
        send_request(make_request(fba_pkg::ACT_FREE, 2, 1'b1, 1'b0));
        send_request(make_request(fba_pkg::ACT_ALLOC, 0, 1'b1, 1'b1));
        send_request(make_request(fba_pkg::ACT_FREE, 0, 1'b1, 1'b1));
    endtask

    task automatic test_frame_count_limits;
        write_frame_count('0);
        send_request(make_request(fba_pkg::ACT_ALLOC, 0, 1'b0, 1'b1));
        send_request(make_request(fba_pkg::ACT_ALLOC, 7, 1'b0, 1'b1));
        // above the bound
        send_request(make_request(fba_pkg::ACT_FREE, 3, 1'b0, 1'b0));
        write_frame_count(fba_pkg::CFG_W'(4));
        send_request(make_request(fba_pkg::ACT_ALLOC, 0, 1'b1, 1'b1));
        // bitmap full
        send_request(make_request(fba_pkg::ACT_ALLOC, 0, 1'b0, 1'b0));
        write_frame_count(fba_pkg::CFG_W'(33));
        send_request(make_request(fba_pkg::ACT_ALLOC, 0, 1'b1, 1'b0));
        // beyond the frame field
        write_frame_count({fba_pkg::CFG_W{1'b1}});
        send_request(make_request(fba_pkg::ACT_ALLOC, 0, 1'b0, 1'b1));
        write_frame_count(fba_pkg::CFG_W'(fba_pkg::COUNT_RESET));
        send_request(make_request(fba_pkg::ACT_ALLOC, 0, 1'b1, 1'b1));
        send_request(make_request(fba_pkg::ACT_FREE, 4000, 1'b0, 1'b0));
    endtask

    task automatic test_output_hold_off;
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_for_results();
        @(posedge aclk);
        hold_request = HOLD_CYCLES;
        @(negedge aclk);
        // keep offering while the result side is stalled
        for (i = 0; i < 16; i++)
            send_request(make_request(i[0] ? fba_pkg::ACT_FREE : fba_pkg::ACT_ALLOC,
                                      i[0] ? i : 0, i[1], i[2]));
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        fba_pkg::in_item_t          w;
        logic [fba_pkg::CFG_W-1:0]  count;
        int                         phase, n, pick, idx;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: count = fba_pkg::CFG_W'($urandom_range(1, 70));
                1: count = ($urandom_range(1)) ? fba_pkg::CFG_W'(32) : fba_pkg::CFG_W'(64);
                2: count = ($urandom_range(1)) ? fba_pkg::CFG_W'(fba_pkg::COUNT_RESET)
                                               : {fba_pkg::CFG_W{1'b1}};
                default: count = fba_pkg::CFG_W'($urandom_range(0, (1 << fba_pkg::CFG_W) - 1));
            endcase
            write_frame_count(count);
            for (n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(99);
                if (pick < 50) begin
                    w = make_request(fba_pkg::ACT_ALLOC, 0, 1'($urandom_range(1)),
                                     1'($urandom_range(1)));
                end else if (pick < 80 && held_frames.size() != 0) begin
                    idx = $urandom_range(held_frames.size() - 1);
                    w = make_request(fba_pkg::ACT_FREE, held_frames[idx],
                                     1'($urandom_range(1)), 1'($urandom_range(1)));
                    held_frames.delete(idx);
                end else begin
                    // noise: mapped entries, stray frees, zero frames
                    w = make_request($urandom_range(1) ? fba_pkg::ACT_FREE : fba_pkg::ACT_ALLOC,
                                     $urandom_range(7) == 0 ? 0 : $urandom_range(4095),
                                     1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                send_request(w);
                if (last_entry.status == fba_pkg::ST_ALLOCATED && last_entry.frame_out != 0)
                    held_frames.push_back(32'(last_entry.frame_out));
            end
        end
    endtask

    // result side ready pattern, with an occasional long stall
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        fba_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_entries.size() == 0) begin
                note_error($sformatf("result word with nothing pending: status %0d frame %0d",
                                     m_data.status, m_data.frame_out));
            end else begin
                want = awaited_entries.pop_front();
                if (m_data.status !== want.status)
                    note_error($sformatf("status: expected %0d, got %0d",
                                         want.status, m_data.status));
                if (m_data.frame_out !== want.frame_out)
                    note_error($sformatf("frame_out: expected %0d, got %0d",
                                         want.frame_out, m_data.frame_out));
                if (m_data.present_bit !== want.present_bit)
                    note_error($sformatf("present_bit: expected %0b, got %0b",
                                         want.present_bit, m_data.present_bit));
                if (m_data.rw_bit !== want.rw_bit)
                    note_error($sformatf("rw_bit: expected %0b, got %0b",
                                         want.rw_bit, m_data.rw_bit));
                if (m_data.user_bit !== want.user_bit)
                    note_error($sformatf("user_bit: expected %0b, got %0b",
                                         want.user_bit, m_data.user_bit));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d results pending",
                     quiet_cycles, awaited_entries.size());
            $display("frame_bitmap_allocator_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        frame_used   = '0;
        frame_limit  = fba_pkg::CFG_W'(fba_pkg::COUNT_RESET);
        hold_request = 0;
        quiet_cycles = 0;
        error_count  = 0;
        send_idle_pct = 22;
        recv_idle_pct = 60;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_requests();
        test_frame_count_limits();
        test_output_hold_off();
        test_random_traffic(22, 60);
        test_random_traffic(60, 22);
        test_random_traffic(0, 0);

        wait_for_results();
        repeat (20) @(posedge aclk);
        if (awaited_entries.size() != 0)
            note_error($sformatf("%0d results never arrived", awaited_entries.size()));

        $display("covered %0d requests over %0d frame count settings", n_requests, n_settings);
        $display("  %0d allocated, %0d already mapped, %0d no free frame, %0d freed, %0d empty",
                 n_alloc, n_mapped, n_no_free, n_freed, n_nothing);
        if (error_count == 0) begin
            $display("frame_bitmap_allocator_top_tb: done, clean");
        end else begin
            $display("%0d mismatches", error_count);
            $display("frame_bitmap_allocator_top_tb: done, errors");
        end
        $finish;
    end

endmodule
